>>> rtl/pol_pkg.sv
// Shared types and constants for the positional ordered list.
// Used by pol_cell and positional_ordered_list_top; no dependencies.
`default_nettype none

package pol_pkg;

  localparam int DEF_CAPACITY      = 64;
  localparam int DEF_ELEMENT_WIDTH = 32;
  localparam int OP_W              = 3;
  localparam int POS_W             = 7;
  localparam int DATA_W            = 32;
  localparam int LEN_W             = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef struct packed {
    logic exec;
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/pol_cell.sv
// One list slot: holds an entry, shifts with its neighbors, flags match and select.
// Depends on pol_pkg for the control struct.
`default_nettype none

module pol_cell
  import pol_pkg::*;
#(
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
  parameter int PW            = 8,
  parameter int IDX           = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic [PW-1:0]            pos0,
  input  wire logic [PW-1:0]            cnt,
  input  wire logic [ELEMENT_WIDTH-1:0] val,
  input  wire logic [ELEMENT_WIDTH-1:0] left_data,
  input  wire logic [ELEMENT_WIDTH-1:0] right_data,
  output logic      [ELEMENT_WIDTH-1:0] data_out,
  output logic                          match_r,
  output logic      [ELEMENT_WIDTH-1:0] rd_r
);

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic [ELEMENT_WIDTH-1:0] data_r;
  logic [ELEMENT_WIDTH-1:0] data_nxt;
  logic                     match_nxt;
  logic [ELEMENT_WIDTH-1:0] rd_nxt;

  assign data_out = data_r;

  always_comb begin
    data_nxt = data_r;
    priority if (ctrl.ins && (MY_IDX == pos0)) begin
      data_nxt = val;
    end else if (ctrl.ins && (MY_IDX > pos0)) begin
      data_nxt = left_data;
    end else if (ctrl.del && (MY_IDX >= pos0)) begin
      data_nxt = right_data;
    end else begin
      data_nxt = data_r;
    end
    match_nxt = (MY_IDX < cnt) && (data_r == val);
    rd_nxt    = (MY_IDX == pos0) ? data_r : '0;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctrl.exec) begin
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.exec) begin
      match_r <= match_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/positional_ordered_list_top.sv
// Positional ordered list top: request register, row of pol_cell slots, result reduce.
// Depends on pol_pkg and pol_cell.
//
// A fixed-capacity list addressed by 1-based position. Each request passes three
// registers: the request register at the accepting edge, the slots at the next edge,
// where every slot shifts in parallel and flags its match and select, and the output
// register, loaded once the output side does not stall, where the flags of the row are
// reduced to found_at and read_value. The block takes one request at a time; the next
// one can be accepted at the edge after the result is loaded into the output register,
// so a new request waits while the result is held back by a stall.
// Entries come up undefined and need no clearing pass.
`default_nettype none

module positional_ordered_list_top
  import pol_pkg::*;
#(
  parameter int CAPACITY      = DEF_CAPACITY,
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [POS_W-1:0]  in_position,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_status,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [LEN_W-1:0]       out_found_at,
  output logic [LEN_W-1:0]       out_list_length,
  output logic                   out_is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int EW = ELEMENT_WIDTH;

  logic                 req_v_r;
  logic [OP_W-1:0]      req_op_r;
  logic [POS_W-1:0]     req_pos_r;
  logic [EW-1:0]        req_val_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;

  logic                 fin_v_r;
  logic                 fin_err_r;
  logic                 fin_rd_en_r;
  logic                 fin_loc_r;

  logic                 in_take;
  logic                 out_load;
  logic [EW+63:0]       val_ext;

  logic [PW-1:0]        pos_w;
  logic [PW-1:0]        cnt_w;
  logic [PW-1:0]        pos0;
  logic                 pos_ok;
  logic                 ins_ok;
  logic                 req_ok;
  cell_ctrl_t           ctrl;

  logic [EW-1:0]        cell_data [CAPACITY];
  logic [EW-1:0]        cell_rd   [CAPACITY];
  logic [CAPACITY-1:0]  cell_match;

  logic [CW-1:0]        hit;
  logic [EW-1:0]        rd_or;
  logic [EW+31:0]       rd_ext;

  assign in_stall = req_v_r | fin_v_r;
  assign in_take  = in_valid & ~in_stall;
  assign out_load = fin_v_r & ~(out_valid & out_stall);
  assign val_ext  = {{(EW + 32){in_value[DATA_W-1]}}, in_value};

  // Request stage
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_op_r  <= in_op;
      req_pos_r <= in_position;
      req_val_r <= val_ext[EW-1:0];
    end
  end

  // Decode against the current length
  always_comb begin
    pos_w  = PW'(req_pos_r);
    cnt_w  = PW'(count_r);
    pos0   = pos_w - PW'(1);
    pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
    ins_ok = (pos_w != '0) && (pos_w <= cnt_w + PW'(1)) && (cnt_w < PW'(CAPACITY));
    unique case (req_op_r)
      OP_INSERT: req_ok = ins_ok;
      OP_DELETE: req_ok = pos_ok;
      OP_GET:    req_ok = pos_ok;
      OP_LOCATE: req_ok = 1'b1;
      OP_CLEAR:  req_ok = 1'b1;
      default:   req_ok = 1'b0;
    endcase
    ctrl.exec = req_v_r;
    ctrl.ins  = req_v_r && (req_op_r == OP_INSERT) && ins_ok;
    ctrl.del  = req_v_r && (req_op_r == OP_DELETE) && pos_ok;
    count_nxt = count_r;
    priority if (ctrl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.del) begin
      count_nxt = count_r - CW'(1);
    end else if (req_v_r && (req_op_r == OP_CLEAR)) begin
      count_nxt = '0;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r   <= 1'b0;
      fin_v_r   <= 1'b0;
      out_valid <= 1'b0;
      count_r   <= '0;
    end else begin
      count_r <= count_nxt;
      if (in_take) begin
        req_v_r <= 1'b1;
      end else if (req_v_r) begin
        req_v_r <= 1'b0;
      end
      if (req_v_r) begin
        fin_v_r <= 1'b1;
      end else if (out_load) begin
        fin_v_r <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_v_r) begin
      fin_err_r   <= ~req_ok;
      fin_rd_en_r <= req_ok &&
                     ((req_op_r == OP_GET) || (req_op_r == OP_DELETE));
      fin_loc_r   <= (req_op_r == OP_LOCATE);
    end
  end

  // Row of slots
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [EW-1:0] left_d;
    logic [EW-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[g+1];
    end
    pol_cell #(
      .ELEMENT_WIDTH (EW),
      .PW            (PW),
      .IDX           (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .pos0       (pos0),
      .cnt        (cnt_w),
      .val        (req_val_r),
      .left_data  (left_d),
      .right_data (right_d),
      .data_out   (cell_data[g]),
      .match_r    (cell_match[g]),
      .rd_r       (cell_rd[g])
    );
  end

  // Reduce row flags
  always_comb begin
    hit   = '0;
    rd_or = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        hit = CW'(i + 1);
      end
    end
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
    rd_ext = {32'b0, rd_or};
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status      <= fin_err_r;
      out_read_value  <= fin_rd_en_r ? rd_ext[DATA_W-1:0] : '0;
      out_found_at    <= fin_loc_r ? LEN_W'(hit) : '0;
      out_list_length <= LEN_W'(count_r);
      out_is_empty    <= (count_r == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("length beyond capacity");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(req_v_r && fin_v_r))
    else $error("two requests in flight");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_found_at != '0)) |-> (out_found_at <= out_list_length))
    else $error("found position beyond length");

endmodule

`default_nettype wire
